>>> design/rm2q_pkg.sv
// Package for the rotation matrix to quaternion converter.
// Holds the fixed-point constants, branch codes and the word types of both channels.
// No dependencies.
package rm2q_pkg;

  // Q2.14 format
  localparam int FRAC_BITS = 14;
  localparam int QW        = 16;
  // Saturation limit: 1.0, no more than the largest positive 16 bit value
  localparam int QLIM_INT  = ((1 << FRAC_BITS) > 32767) ? 32767 : (1 << FRAC_BITS);
  localparam logic [QW-1:0] QLIM = QW'(QLIM_INT);

  // Pipeline depth of the iterative units
  localparam int SQ_STAGES = 16;   // one root bit per stage
  localparam int DV_STAGES = 15;   // one quotient bit per stage

  // Branch codes
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // Register map
  localparam logic [0:0] REG_TIE_TOL = 1'b0;
  localparam int         TOL_W       = 10;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  typedef struct packed {
    logic signed [QW-1:0] r00;
    logic signed [QW-1:0] r01;
    logic signed [QW-1:0] r02;
    logic signed [QW-1:0] r10;
    logic signed [QW-1:0] r11;
    logic signed [QW-1:0] r12;
    logic signed [QW-1:0] r20;
    logic signed [QW-1:0] r21;
    logic signed [QW-1:0] r22;
  } in_word_t;

  typedef struct packed {
    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    logic [1:0]           branch_used;
  } out_word_t;

endpackage

>>> design/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter (Shepperd method), fully pipelined.
// Depends on rm2q_pkg for constants and channel word types.
// Pipeline: 35 register stages, set by the 16 root-bit stages of the square root,
//   the 15 quotient-bit stages of the dividers and four stages of setup and output.
// Throughput: one word per cycle; a stalled output holds the pipeline while bubbles
//   inside it still close up, so input is taken until every stage is full.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets tie_tolerance to 1.
module rotation_matrix_to_quaternion (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rm2q_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rm2q_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rm2q_pkg::*;

  localparam int ST_A    = 0;
  localparam int ST_B    = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_PREP = ST_SQ + SQ_STAGES;
  localparam int ST_DV   = ST_PREP + 1;
  localparam int ST_OUT  = ST_DV + DV_STAGES;
  localparam int NST     = ST_OUT + 1;

  typedef struct packed {
    logic               trace_pos;
    logic               x_match;
    logic               y_match;
    logic signed [17:0] rad_t;
    logic signed [17:0] rad_x;
    logic signed [17:0] rad_y;
    logic signed [17:0] rad_z;
    logic signed [16:0] d21_12;
    logic signed [16:0] d02_20;
    logic signed [16:0] d10_01;
    logic signed [16:0] s01_10;
    logic signed [16:0] s02_20;
    logic signed [16:0] s12_21;
  } sa_t;

  typedef struct packed {
    logic [1:0]              branch;
    logic [2:0][16:0]        num;
    logic [31:0]             v;
    logic [18:0]             rem;
    logic [15:0]             root;
  } sq_t;

  typedef struct packed {
    logic [1:0]              branch;
    logic [15:0]             dom;
    logic [16:0]             den;
    logic [2:0]              neg;
    logic [2:0]              ovf;
    logic [2:0][31:0]        rem;
    logic [2:0][14:0]        q;
  } dv_t;

  // ---------------- configuration port
  logic [TOL_W-1:0] tol_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TIE_TOL)) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIE_TOL) begin
      prdata = {{(32-TOL_W){1'b0}}, tol_r};
    end
  end

  // ---------------- stage enables: a stage loads when it is empty or moves on
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST-2; k >= 0; k--) begin
      en[k] = en[k+1] || !vld_r[k];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------- stage A: trace, diagonal max, radicands, numerators
  sa_t sa_r, sa_nxt;

  always_comb begin
    logic signed [17:0] e00, e11, e22, one, mx, tol;
    e00 = 18'(in_data.r00);
    e11 = 18'(in_data.r11);
    e22 = 18'(in_data.r22);
    one = 18'(1 << FRAC_BITS);
    tol = $signed({8'b0, tol_r});
    mx  = e00;
    if (e11 > mx) mx = e11;
    if (e22 > mx) mx = e22;
    sa_nxt.rad_t     = one + e00 + e11 + e22;
    sa_nxt.trace_pos = sa_nxt.rad_t > 18'sd0;
    sa_nxt.x_match   = (mx - e00) < tol;
    sa_nxt.y_match   = (mx - e11) < tol;
    sa_nxt.rad_x     = one + e00 - e11 - e22;
    sa_nxt.rad_y     = one + e11 - e00 - e22;
    sa_nxt.rad_z     = one + e22 - e00 - e11;
    sa_nxt.d21_12    = 17'(in_data.r21) - 17'(in_data.r12);
    sa_nxt.d02_20    = 17'(in_data.r02) - 17'(in_data.r20);
    sa_nxt.d10_01    = 17'(in_data.r10) - 17'(in_data.r01);
    sa_nxt.s01_10    = 17'(in_data.r01) + 17'(in_data.r10);
    sa_nxt.s02_20    = 17'(in_data.r02) + 17'(in_data.r20);
    sa_nxt.s12_21    = 17'(in_data.r12) + 17'(in_data.r21);
  end

  always_ff @(posedge clk) begin
    if (en[ST_A]) sa_r <= sa_nxt;
  end

  // ---------------- stage B: pick branch, clamp radicand, order numerators
  sq_t sb_r, sb_nxt;

  always_comb begin
    logic signed [17:0] rad;
    sb_nxt = '0;
    if (sa_r.trace_pos) begin
      sb_nxt.branch = BR_TRACE;
      rad           = sa_r.rad_t;
      sb_nxt.num    = {sa_r.d10_01, sa_r.d02_20, sa_r.d21_12};
    end else if (sa_r.x_match) begin
      sb_nxt.branch = BR_X;
      rad           = sa_r.rad_x;
      sb_nxt.num    = {sa_r.s02_20, sa_r.s01_10, sa_r.d21_12};
    end else if (sa_r.y_match) begin
      sb_nxt.branch = BR_Y;
      rad           = sa_r.rad_y;
      sb_nxt.num    = {sa_r.s12_21, sa_r.s01_10, sa_r.d02_20};
    end else begin
      sb_nxt.branch = BR_Z;
      rad           = sa_r.rad_z;
      sb_nxt.num    = {sa_r.s12_21, sa_r.s02_20, sa_r.d10_01};
    end
    if (rad < 18'sd1) rad = 18'sd1;
    // radicand in Q.28 for the root
    sb_nxt.v = {1'b0, rad[16:0], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[ST_B]) sb_r <= sb_nxt;
  end

  // ---------------- square root: one root bit per stage
  sq_t sq_r   [SQ_STAGES];
  sq_t sq_src [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
    sq_t nxt;
    if (g == 0) begin : g_first
      assign sq_src[g] = sb_r;
    end else begin : g_rest
      assign sq_src[g] = sq_r[g-1];
    end

    always_comb begin
      logic [18:0] rem_sh, trial;
      logic        ge;
      rem_sh   = {sq_src[g].rem[16:0], sq_src[g].v[31:30]};
      trial    = {1'b0, sq_src[g].root, 2'b01};
      ge       = rem_sh >= trial;
      nxt      = sq_src[g];
      nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
      nxt.root = {sq_src[g].root[14:0], ge};
      nxt.v    = {sq_src[g].v[29:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (en[ST_SQ+g]) sq_r[g] <= nxt;
    end
  end

  // ---------------- prep: dominant term, divider operands, overflow check
  dv_t pr_r, pr_nxt;

  always_comb begin
    logic [15:0] d;
    logic [16:0] dsum;
    logic [31:0] lim;
    logic [16:0] mag;
    d             = sq_r[SQ_STAGES-1].root;
    dsum          = {1'b0, d} + 17'd1;
    pr_nxt.branch = sq_r[SQ_STAGES-1].branch;
    pr_nxt.dom    = dsum[16:1];
    pr_nxt.den    = {d, 1'b0};
    pr_nxt.q      = '0;
    lim           = {d, 1'b0, 15'b0};
    for (int k = 0; k < 3; k++) begin
      pr_nxt.neg[k] = sq_r[SQ_STAGES-1].num[k][16];
      mag = pr_nxt.neg[k] ? (17'd0 - sq_r[SQ_STAGES-1].num[k]) : sq_r[SQ_STAGES-1].num[k];
      // rounding: (|n| * ONE + d) / (2d)
      pr_nxt.rem[k] = {1'b0, mag, {FRAC_BITS{1'b0}}} + {16'b0, d};
      pr_nxt.ovf[k] = pr_nxt.rem[k] >= lim;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PREP]) pr_r <= pr_nxt;
  end

  // ---------------- dividers: three lanes, one quotient bit per stage
  dv_t dv_r   [DV_STAGES];
  dv_t dv_src [DV_STAGES];

  for (genvar g = 0; g < DV_STAGES; g++) begin : g_dv
    dv_t nxt;
    if (g == 0) begin : g_first
      assign dv_src[g] = pr_r;
    end else begin : g_rest
      assign dv_src[g] = dv_r[g-1];
    end

    always_comb begin
      logic [31:0] cmp;
      logic        ge;
      nxt = dv_src[g];
      cmp = {15'b0, dv_src[g].den} << (DV_STAGES - 1 - g);
      for (int k = 0; k < 3; k++) begin
        ge         = dv_src[g].rem[k] >= cmp;
        nxt.rem[k] = ge ? (dv_src[g].rem[k] - cmp) : dv_src[g].rem[k];
        nxt.q[k]   = {dv_src[g].q[k][13:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DV+g]) dv_r[g] <= nxt;
    end
  end

  // ---------------- output: saturate, sign, place by branch
  out_word_t out_r, out_nxt;

  always_comb begin
    dv_t                  f;
    logic [15:0]          mag;
    logic signed [15:0]   c [3];
    logic signed [15:0]   dom;
    f = dv_r[DV_STAGES-1];
    for (int k = 0; k < 3; k++) begin
      mag  = (f.ovf[k] || ({1'b0, f.q[k]} > QLIM)) ? QLIM : {1'b0, f.q[k]};
      c[k] = f.neg[k] ? $signed(16'd0 - mag) : $signed(mag);
    end
    dom = $signed((f.dom > QLIM) ? QLIM : f.dom);
    out_nxt.branch_used = f.branch;
    case (f.branch)
      BR_TRACE: begin
        out_nxt.qw = dom;  out_nxt.qx = c[0]; out_nxt.qy = c[1]; out_nxt.qz = c[2];
      end
      BR_X: begin
        out_nxt.qw = c[0]; out_nxt.qx = dom;  out_nxt.qy = c[1]; out_nxt.qz = c[2];
      end
      BR_Y: begin
        out_nxt.qw = c[0]; out_nxt.qx = c[1]; out_nxt.qy = dom;  out_nxt.qz = c[2];
      end
      default: begin
        out_nxt.qw = c[0]; out_nxt.qx = c[1]; out_nxt.qy = c[2]; out_nxt.qz = dom;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) out_r <= out_nxt;
  end

  assign out_valid = vld_r[ST_OUT];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // input only held back when the whole pipeline is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&vld_r)))
    else $error("input stalled with room in the pipeline");

  // every component stays within the saturation limit
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.qw) >= -16384 && $signed(out_data.qw) <= 16384 &&
                   $signed(out_data.qx) >= -16384 && $signed(out_data.qx) <= 16384 &&
                   $signed(out_data.qy) >= -16384 && $signed(out_data.qy) <= 16384 &&
                   $signed(out_data.qz) >= -16384 && $signed(out_data.qz) <= 16384))
    else $error("quaternion component out of range");

  // the trace branch puts a non-negative root into w
  a_trace_w: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.branch_used == BR_TRACE) |-> ($signed(out_data.qw) >= 0))
    else $error("negative w in trace branch");

  // a held result moves the tail stage nowhere
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  // tolerance comes out of reset at its default
  a_tol_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (tol_r == TOL_RESET))
    else $error("tie tolerance not at reset value");
`endif

endmodule

>>> tb/tb.sv
// Testbench for rotation_matrix_to_quaternion: random and directed matrices,
// predicted quaternions compared word by word. Depends on rm2q_pkg and the DUT.
`timescale 1ns / 1ps

module tb;
  import rm2q_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  localparam int LATENCY = 35;
  localparam longint CYCLE_LIMIT = 400000;

  // predictor state
  logic [TOL_W-1:0] tol_q = TOL_RESET;

  in_word_t  pending_words[$];
  out_word_t expected_quats[$];
  int  mismatches = 0;
  int  accepted = 0, received = 0;
  int  branch_hits[4] = '{0, 0, 0, 0};
  bit  stim_done = 1'b0;
  bit  hold_sender = 1'b0;
  longint cycles = 0;
  logic [TOL_W-1:0] tols[4];

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // n / (2d) in Q format, round half away from zero
  function automatic longint div_q(longint n, longint unsigned d);
    longint unsigned m, q;
    m = ((n < 0) ? -n : n) << FRAC_BITS;
    q = (m + d) / (2 * d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [QW-1:0] clamp_q(longint v);
    longint lim;
    lim = QLIM_INT;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[QW-1:0];
  endfunction

  function automatic out_word_t quat_of(in_word_t m, logic [TOL_W-1:0] tol);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint one, tr, rad, mx, w, x, y, z, dom;
    longint unsigned d;
    logic [1:0] br;
    out_word_t o;
    one = 1 << FRAC_BITS;
    a00 = m.r00; a01 = m.r01; a02 = m.r02;
    a10 = m.r10; a11 = m.r11; a12 = m.r12;
    a20 = m.r20; a21 = m.r21; a22 = m.r22;
    tr = one + a00 + a11 + a22;
    if (tr > 0) begin
      br = BR_TRACE;
      rad = tr;
    end else begin
      mx = a00;
      if (a11 > mx) mx = a11;
      if (a22 > mx) mx = a22;
      if (mx - a00 < longint'(tol)) begin
        br = BR_X; rad = one + a00 - a11 - a22;
      end else if (mx - a11 < longint'(tol)) begin
        br = BR_Y; rad = one + a11 - a00 - a22;
      end else begin
        br = BR_Z; rad = one + a22 - a00 - a11;
      end
      if (rad < 1) rad = 1;
    end
    d = root64(longint'(rad) << FRAC_BITS);
    dom = (d + 1) >> 1;
    case (br)
      BR_TRACE: begin
        w = dom; x = div_q(a21 - a12, d); y = div_q(a02 - a20, d); z = div_q(a10 - a01, d);
      end
      BR_X: begin
        x = dom; y = div_q(a01 + a10, d); z = div_q(a02 + a20, d); w = div_q(a21 - a12, d);
      end
      BR_Y: begin
        y = dom; x = div_q(a01 + a10, d); z = div_q(a12 + a21, d); w = div_q(a02 - a20, d);
      end
      default: begin
        z = dom; x = div_q(a02 + a20, d); y = div_q(a12 + a21, d); w = div_q(a10 - a01, d);
      end
    endcase
    o.qw = clamp_q(w); o.qx = clamp_q(x); o.qy = clamp_q(y); o.qz = clamp_q(z);
    o.branch_used = br;
    return o;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_quats.push_back(quat_of(in_data, tol_q));
        branch_hits[expected_quats[$].branch_used]++;
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && !hold_sender && gap_left == 0) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // receiver: own stall pattern, with quiet stretches
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 300) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99, 0) < ((stall_phase / 300) % 3 == 1 ? 20 : 60));
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      received++;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data);
      end else begin
        out_word_t e;
        e = expected_quats.pop_front();
        if (e.qw !== out_data.qw || e.qx !== out_data.qx || e.qy !== out_data.qy ||
            e.qz !== out_data.qz || e.branch_used !== out_data.branch_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected %p got %p", received, e, out_data);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rotation_matrix_to_quaternion: mismatch");
      $finish;
    end
  end

  task automatic write_tol(input logic [TOL_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(REG_TIE_TOL) << 2; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tol_q <= v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_quats.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(9, 0))
      0: return 16'(16384);
      1: return 16'(-16384);
      2: return 16'($urandom_range(65535, 0));
      3: return 16'(0);
      default: return 16'($urandom_range(32768, 0) - 16384);
    endcase
  endfunction

  // random rotation-like matrix via a quaternion, or noise
  function automatic in_word_t rand_matrix();
    in_word_t m;
    real a, b, c, dd, n;
    if ($urandom_range(4, 0) == 0) begin
      m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
           rand_elem(), rand_elem(), rand_elem(), rand_elem()};
      return m;
    end
    a = $urandom_range(2000, 0) - 1000.0; b = $urandom_range(2000, 0) - 1000.0;
    c = $urandom_range(2000, 0) - 1000.0; dd = $urandom_range(2000, 0) - 1000.0;
    n = $sqrt(a*a + b*b + c*c + dd*dd) + 1e-9;
    a /= n; b /= n; c /= n; dd /= n;
    m.r00 = 16'($rtoi(16384.0 * (1 - 2*(c*c + dd*dd))));
    m.r01 = 16'($rtoi(16384.0 * 2*(b*c - dd*a)));
    m.r02 = 16'($rtoi(16384.0 * 2*(b*dd + c*a)));
    m.r10 = 16'($rtoi(16384.0 * 2*(b*c + dd*a)));
    m.r11 = 16'($rtoi(16384.0 * (1 - 2*(b*b + dd*dd))));
    m.r12 = 16'($rtoi(16384.0 * 2*(c*dd - b*a)));
    m.r20 = 16'($rtoi(16384.0 * 2*(b*dd - c*a)));
    m.r21 = 16'($rtoi(16384.0 * 2*(c*dd + b*a)));
    m.r22 = 16'($rtoi(16384.0 * (1 - 2*(b*b + c*c))));
    return m;
  endfunction

  function automatic in_word_t diag(int a, int b, int c);
    in_word_t m;
    m = '0;
    m.r00 = 16'(a); m.r11 = 16'(b); m.r22 = 16'(c);
    return m;
  endfunction

  initial begin
    in_word_t m;
    tols = '{10'd0, 10'd1023, 10'd5, 10'd1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity, half turns, ties, extremes, non-rotations
    pending_words.push_back(diag(16384, 16384, 16384));
    pending_words.push_back(diag(16384, -16384, -16384));
    pending_words.push_back(diag(-16384, 16384, -16384));
    pending_words.push_back(diag(-16384, -16384, 16384));
    pending_words.push_back(diag(-16384, -16384, -16384));
    pending_words.push_back(diag(-8192, -8192, -8192));
    pending_words.push_back(diag(-8192, -8192, -8193));
    pending_words.push_back(diag(-32768, -32768, -32768));
    pending_words.push_back(diag(32767, -32768, -32768));
    pending_words.push_back(diag(-16384, 0, 0));
    m = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
          16'h7fff, 16'h8000, 16'h7fff};
    pending_words.push_back(m);
    m = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
          16'h8000, 16'h7fff, 16'h8000};
    pending_words.push_back(m);
    m = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
          16'hffff, 16'hffff, 16'hffff};
    pending_words.push_back(m);
    pending_words.push_back('0);
    pending_words.push_back(diag(-16384, -16383, 0));
    pending_words.push_back(diag(0, -16383, -16384));
    drain();

    // random phases across tolerance settings
    foreach (tols[i]) begin
      write_tol(tols[i]);
      for (int k = 0; k < 420; k++) begin
        if (k == 200) begin
          // sender waits until the pipeline is empty
          while (pending_words.size() > 0 || in_valid) @(posedge clk);
          hold_sender = 1'b1;
          while (expected_quats.size() > 0) @(posedge clk);
          hold_sender = 1'b0;
        end
        pending_words.push_back(rand_matrix());
      end
      drain();
    end

    $display("%0d matrices, branches trace/x/y/z = %0d/%0d/%0d/%0d, tolerances 0..1023",
             accepted, branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3]);
    if (mismatches == 0 && expected_quats.size() == 0)
      $display("rotation_matrix_to_quaternion: match");
    else begin
      $display("%0d mismatches, %0d left over", mismatches, expected_quats.size());
      $display("rotation_matrix_to_quaternion: mismatch");
    end
    $finish;
  end
endmodule
